/* rtl/core/fwa_pkg.sv */
package fwa_pkg;

  // Field widths that the interface fixes.
  localparam int UNIT_BITS = 5;

  // The divisor is the history count plus one, at most 16.
  localparam int DIV_BITS = 5;

  // The divider retires one radix-16 quotient digit per cycle.
  localparam int DIGIT_BITS = 4;

  // A sum of up to 16 coordinates needs four bits above the coordinate width.
  localparam int GROWTH_BITS = 4;

  localparam int NUM_UNITS_DEF     = 32;
  localparam int HISTORY_DEPTH_DEF = 5;
  localparam int COORD_BITS_DEF    = 24;

  typedef struct packed {
    logic                load;
    logic                rd_en;
    logic                div_start;
    logic                wr_en;
    logic [DIV_BITS-1:0] divisor;
  } lane_ctrl_t;

endpackage

/* rtl/core/fwa_div.sv */
module fwa_div #(
  parameter int SUM_BITS = fwa_pkg::COORD_BITS_DEF + fwa_pkg::GROWTH_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [SUM_BITS-1:0]               dividend_i,
  input  logic [fwa_pkg::DIV_BITS-1:0]      divisor_i,
  output logic [((SUM_BITS + fwa_pkg::DIGIT_BITS - 1) / fwa_pkg::DIGIT_BITS)
                * fwa_pkg::DIGIT_BITS - 1:0] quot_o,
  output logic                              done_o
);

  localparam int DB  = fwa_pkg::DIGIT_BITS;
  localparam int ND  = (SUM_BITS + DB - 1) / DB;
  localparam int DW  = ND * DB;
  localparam int STW = $clog2(ND + 1);

  logic [DW-1:0]                 dvd_q;
  logic [DB-1:0]                 rem_q, rem_d;
  logic [fwa_pkg::DIV_BITS-1:0]  n_q;
  logic [STW-1:0]                step_q;
  logic [2*DB-1:0]               cur;
  logic [DB-1:0]                 digit;

  // The partial remainder stays below the divisor, so the next digit is the
  // largest multiple that fits under the remainder with one digit shifted in.
  always_comb begin
    cur   = {rem_q, dvd_q[DW-1 -: DB]};
    digit = '0;
    for (int m = 1; m < (1 << DB); m++) begin
      if (cur >= (2*DB)'(n_q * m)) begin
        digit = DB'(m);
      end
    end
    rem_d = DB'(cur - (2*DB)'(n_q) * (2*DB)'(digit));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= STW'(ND);
    end else if (step_q != '0) begin
      step_q <= step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= DW'(dividend_i);
      rem_q <= '0;
      n_q   <= divisor_i;
    end else if (step_q != '0) begin
      dvd_q <= {dvd_q[DW-DB-1:0], digit};
      rem_q <= rem_d;
    end
  end

  assign quot_o = dvd_q;
  assign done_o = (step_q == '0);

endmodule

/* rtl/core/fwa_lane.sv */
module fwa_lane #(
  parameter int NUM_UNITS     = fwa_pkg::NUM_UNITS_DEF,
  parameter int HISTORY_DEPTH = fwa_pkg::HISTORY_DEPTH_DEF,
  parameter int COORD_BITS    = fwa_pkg::COORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fwa_pkg::lane_ctrl_t      ctrl_i,
  input  logic [(NUM_UNITS * HISTORY_DEPTH > 1 ?
                 $clog2(NUM_UNITS * HISTORY_DEPTH) : 1) - 1:0] rd_addr_i,
  input  logic [(NUM_UNITS * HISTORY_DEPTH > 1 ?
                 $clog2(NUM_UNITS * HISTORY_DEPTH) : 1) - 1:0] wr_addr_i,
  input  logic signed [COORD_BITS-1:0] target_i,
  output logic signed [COORD_BITS-1:0] result_o,
  output logic                     done_o
);

  localparam int ENTRIES   = NUM_UNITS * HISTORY_DEPTH;
  localparam int SUM_BITS  = COORD_BITS + fwa_pkg::GROWTH_BITS;
  localparam int QUOT_BITS = ((SUM_BITS + fwa_pkg::DIGIT_BITS - 1) / fwa_pkg::DIGIT_BITS)
                             * fwa_pkg::DIGIT_BITS;

  logic [COORD_BITS-1:0]        mem_q [ENTRIES];
  logic signed [COORD_BITS-1:0] rd_data_q;
  logic                         rd_vld_q;
  logic signed [SUM_BITS-1:0]   acc_q;
  logic                         neg_q;
  logic [SUM_BITS-1:0]          mag;
  logic [SUM_BITS-1:0]          dividend;
  logic [QUOT_BITS-1:0]         quot;
  logic [COORD_BITS-1:0]        q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= result_o;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= ctrl_i.rd_en;
    end
  end

  // The sum starts from the target and takes one history entry per cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q <= SUM_BITS'(target_i);
    end else if (rd_vld_q) begin
      acc_q <= acc_q + SUM_BITS'(rd_data_q);
    end
    if (ctrl_i.div_start) begin
      neg_q <= acc_q[SUM_BITS-1];
    end
  end

  // Rounding to nearest with ties away from zero works on the magnitude.
  assign mag      = acc_q[SUM_BITS-1] ? (~acc_q + 1'b1) : acc_q;
  assign dividend = mag + SUM_BITS'(ctrl_i.divisor >> 1);

  fwa_div #(
    .SUM_BITS (SUM_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (ctrl_i.divisor),
    .quot_o     (quot),
    .done_o     (done_o)
  );

  assign q        = quot[COORD_BITS-1:0];
  assign result_o = neg_q ? (~q + 1'b1) : q;

endmodule

/* rtl/core/feedback_window_average.sv */
// Channel  Direction  Handshake                  Item
// in       input      in_valid_i / in_stall_o    unit_index_i, target_x_i/y_i/z_i
// out      output     out_valid_o / out_stall_i  unit_echo_o, smooth_x_o/y_o/z_o
//
// Each item takes one history read per stored entry, then one radix-16 quotient
// digit per cycle in each axis lane.
// Reset clears the per-unit fill counts and ring pointers; history holds no reset.
// A new item is taken while a finished result waits in the output register.
module feedback_window_average #(
  parameter int NUM_UNITS     = fwa_pkg::NUM_UNITS_DEF,
  parameter int HISTORY_DEPTH = fwa_pkg::HISTORY_DEPTH_DEF,
  parameter int COORD_BITS    = fwa_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fwa_pkg::UNIT_BITS-1:0]     unit_index_i,
  input  logic signed [COORD_BITS-1:0]      target_x_i,
  input  logic signed [COORD_BITS-1:0]      target_y_i,
  input  logic signed [COORD_BITS-1:0]      target_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fwa_pkg::UNIT_BITS-1:0]     unit_echo_o,
  output logic signed [COORD_BITS-1:0]      smooth_x_o,
  output logic signed [COORD_BITS-1:0]      smooth_y_o,
  output logic signed [COORD_BITS-1:0]      smooth_z_o
);

  localparam int ENTRIES = NUM_UNITS * HISTORY_DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UIW     = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int CW      = $clog2(HISTORY_DEPTH + 1);
  localparam int SLW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACC   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]                      state_q, state_d;
  logic [fwa_pkg::UNIT_BITS-1:0]   unit_q;
  logic                            in_range_q;
  logic [CW-1:0]                   cnt_q;
  logic [CW-1:0]                   k_q;
  logic [SLW-1:0]                  slot_q;
  logic [CW-1:0]                   fill_q [NUM_UNITS];
  logic [SLW-1:0]                  ring_q [NUM_UNITS];
  logic                            out_vld_q;

  logic                            accept;
  logic                            in_range;
  logic [UIW-1:0]                  in_idx;
  logic [UIW-1:0]                  cur_idx;
  logic                            out_free;
  logic                            commit;
  logic [AW-1:0]                   rd_addr, wr_addr;
  fwa_pkg::lane_ctrl_t             ctrl;
  logic signed [COORD_BITS-1:0]    lane_tgt [3];
  logic signed [COORD_BITS-1:0]    lane_res [3];
  logic [2:0]                      lane_done;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(unit_index_i) < NUM_UNITS);
  assign in_idx     = UIW'(unit_index_i);
  assign cur_idx    = UIW'(unit_q);
  assign out_free   = !out_vld_q || !out_stall_i;
  assign commit     = (state_q == S_OUT) && out_free;

  assign rd_addr = AW'(32'(unit_q) * HISTORY_DEPTH + 32'(k_q));
  assign wr_addr = AW'(32'(unit_q) * HISTORY_DEPTH + 32'(slot_q));

  always_comb begin
    ctrl.load      = accept;
    ctrl.rd_en     = (state_q == S_ACC) && (k_q < cnt_q);
    ctrl.div_start = (state_q == S_START);
    ctrl.wr_en     = commit && in_range_q;
    ctrl.divisor   = fwa_pkg::DIV_BITS'(cnt_q) + 1'b1;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_ACC;
      end
      // The last read lands in the cycle after it is issued.
      S_ACC: begin
        if (k_q == cnt_q) state_d = S_START;
      end
      S_START: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (&lane_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      for (int i = 0; i < NUM_UNITS; i++) begin
        fill_q[i] <= '0;
        ring_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (ctrl.wr_en) begin
        if (cnt_q < CW'(HISTORY_DEPTH)) fill_q[cur_idx] <= cnt_q + 1'b1;
        ring_q[cur_idx] <= (slot_q == SLW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (accept) begin
      k_q <= '0;
    end else if (ctrl.rd_en) begin
      k_q <= k_q + 1'b1;
    end
  end

  // An index beyond the unit count reads nothing and leaves the target as is.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      unit_q     <= unit_index_i;
      in_range_q <= in_range;
      cnt_q      <= in_range ? fill_q[in_idx] : '0;
      slot_q     <= ring_q[in_idx];
    end
    if (commit) begin
      unit_echo_o <= unit_q;
      smooth_x_o  <= lane_res[0];
      smooth_y_o  <= lane_res[1];
      smooth_z_o  <= lane_res[2];
    end
  end

  assign out_valid_o = out_vld_q;

  assign lane_tgt[0] = target_x_i;
  assign lane_tgt[1] = target_y_i;
  assign lane_tgt[2] = target_z_i;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    fwa_lane #(
      .NUM_UNITS     (NUM_UNITS),
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .COORD_BITS    (COORD_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .rd_addr_i (rd_addr),
      .wr_addr_i (wr_addr),
      .target_i  (lane_tgt[g]),
      .result_o  (lane_res[g]),
      .done_o    (lane_done[g])
    );
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_START) |-> (cnt_q <= CW'(HISTORY_DEPTH)))
    else $error("history count exceeds the ring depth");

  a_out_of_range_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_START && !in_range_q) |-> (cnt_q == '0))
    else $error("out-of-range unit uses history");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == S_OUT)
    else $error("result appeared outside the commit step");

  a_write_only_valid_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.wr_en |-> (in_range_q && (&lane_done)))
    else $error("history written before the quotient is ready");

endmodule
